[sv/hpve_pkg.sv]
// Package for the held-position velocity estimator.
// Field widths, register indexes, reset values and adder op codes.
// No dependencies.
package hpve_pkg;

  localparam int VEL_W = 54;
  localparam int SR_W = 20;
  localparam int HL_W = 16;
  localparam int SR_IDX_W = $clog2(SR_W);

  localparam int POSITION_WIDTH_DEF = 32;
  localparam int COUNT_WIDTH_DEF = 16;

  localparam int CFG_IDX_W = 1;
  localparam int CFG_DATA_W = SR_W;

  localparam logic [CFG_IDX_W-1:0] REG_SAMPLE_RATE = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HOLD_LIMIT = 1'd1;

  localparam logic [SR_W-1:0] SAMPLE_RATE_RST = 20'd1000;
  localparam logic [HL_W-1:0] HOLD_LIMIT_RST = 16'd100;

  localparam logic ALU_ADD = 1'b0;
  localparam logic ALU_SUB = 1'b1;

endpackage

[sv/hpve_addsub.sv]
// Shared add/subtract unit of the velocity estimator.
// Result carries one extra bit: borrow on subtract, carry on add.
// Depends on hpve_pkg.
module hpve_addsub import hpve_pkg::*; #(
  parameter int W = 54
) (
  input  logic         op,
  input  logic [W-1:0] a,
  input  logic [W-1:0] b,
  output logic [W:0]   res
);

  always_comb begin
    if (op == ALU_SUB) begin
      res = {1'b0, a} - {1'b0, b};
    end else begin
      res = {1'b0, a} + {1'b0, b};
    end
  end

endmodule

[sv/held_position_velocity_estimator.sv]
// Held-position velocity estimator, top level.
// Uses hpve_pkg and one hpve_addsub shared for abs, multiply, divide and negate.
//
//   channel | handshake               | payload
//   in      | in_valid / in_stall     | in_position
//   out     | out_valid / out_stall   | out_velocity, out_held, out_timed_out
//   cfg     | cfg_valid / cfg_ready   | cfg_index, cfg_data
//
// First sample and unchanged position: result registered on accept, valid in the cycle after.
// Changed position: states ABS, MUL and DIV, then a negate/saturate step before output,
//   all on the shared adder doing one multiply bit and one restoring divide bit per cycle.
// One item in flight; in_stall is high while it is worked on or the output is stalled.
// Reset is synchronous; registers return to sample_rate 1000, hold_limit 100.
// cfg_ready is always high.
module held_position_velocity_estimator import hpve_pkg::*; #(
  parameter int POSITION_WIDTH = POSITION_WIDTH_DEF,
  parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic signed [POSITION_WIDTH-1:0] in_position,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic signed [VEL_W-1:0]          out_velocity,
  output logic                             out_held,
  output logic                             out_timed_out,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [CFG_IDX_W-1:0]             cfg_index,
  input  logic [CFG_DATA_W-1:0]            cfg_data
);

  localparam int MAG_W = POSITION_WIDTH + 1;
  localparam int PROD_W = MAG_W + SR_W;
  localparam int EXT_W = (PROD_W > VEL_W) ? PROD_W : VEL_W;
  localparam int LIM_W = (COUNT_WIDTH > HL_W) ? COUNT_WIDTH : HL_W;
  localparam int STEP_W = $clog2(PROD_W + 1);

  localparam logic [EXT_W-1:0] VNEG = EXT_W'(1) << (VEL_W - 1);
  localparam logic [EXT_W-1:0] VPOS = VNEG - EXT_W'(1);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_ABS = 2'd1;
  localparam logic [1:0] ST_MUL = 2'd2;
  localparam logic [1:0] ST_DIV = 2'd3;

  logic [1:0]                state_r;
  logic                      fin_r;
  logic                      first_r;
  logic [POSITION_WIDTH-1:0] last_pos_r;
  logic [VEL_W-1:0]          last_vel_r;
  logic [COUNT_WIDTH-1:0]    hold_cnt_r;
  logic [SR_W-1:0]           rate_r;
  logic [HL_W-1:0]           limit_r;
  logic                      neg_r;
  logic [MAG_W-1:0]          mag_r;
  logic [EXT_W-1:0]          acc_r;
  logic [COUNT_WIDTH-1:0]    rem_r;
  logic [STEP_W-1:0]         step_r;

  logic                      out_valid_r;
  logic [VEL_W-1:0]          out_vel_r;
  logic                      out_held_r;
  logic                      out_tout_r;

  logic                      in_acc;
  logic                      out_free;
  logic                      out_load;
  logic                      same;
  logic [MAG_W-1:0]          diff;
  logic [COUNT_WIDTH-1:0]    cnt_inc;
  logic [COUNT_WIDTH-1:0]    divisor;
  logic                      inc_tout;
  logic                      one_tout;
  logic                      alu_op;
  logic [EXT_W-1:0]          alu_a;
  logic [EXT_W-1:0]          alu_b;
  logic [EXT_W:0]            alu_res;
  logic [COUNT_WIDTH:0]      trial;
  logic                      div_ok;
  logic                      sat;
  logic [VEL_W-1:0]          vel_nxt;

  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_velocity = out_vel_r;
  assign out_held = out_held_r;
  assign out_timed_out = out_tout_r;

  assign out_free = !out_valid_r || !out_stall;
  assign in_stall = (state_r != ST_IDLE) || fin_r || !out_free;
  assign in_acc = in_valid && !in_stall;

  assign same = (in_position == last_pos_r);
  assign diff = {in_position[POSITION_WIDTH-1], in_position}
              - {last_pos_r[POSITION_WIDTH-1], last_pos_r};

  assign out_load = (fin_r && out_free) || (in_acc && (first_r || same));

  assign cnt_inc = (hold_cnt_r == '1) ? hold_cnt_r : hold_cnt_r + COUNT_WIDTH'(1);
  assign divisor = (hold_cnt_r == '0) ? COUNT_WIDTH'(1) : hold_cnt_r;
  assign inc_tout = (LIM_W'(cnt_inc) >= LIM_W'(limit_r));
  assign one_tout = (LIM_W'(1) >= LIM_W'(limit_r));

  assign trial = {rem_r, acc_r[PROD_W-1]};

  always_comb begin
    alu_op = ALU_ADD;
    alu_a = '0;
    alu_b = '0;
    if (fin_r) begin
      alu_op = ALU_SUB;
      alu_b = acc_r;
    end else begin
      unique case (state_r)
        ST_ABS: begin
          alu_op = ALU_SUB;
          alu_b = EXT_W'(mag_r);
        end
        ST_MUL: begin
          alu_a = EXT_W'({acc_r[PROD_W-2:0], 1'b0});
          alu_b = rate_r[step_r[SR_IDX_W-1:0]] ? EXT_W'(mag_r) : '0;
        end
        ST_DIV: begin
          alu_op = ALU_SUB;
          alu_a = EXT_W'(trial);
          alu_b = EXT_W'(divisor);
        end
        default: begin
        end
      endcase
    end
  end

  hpve_addsub #(.W(EXT_W)) u_addsub (
    .op  (alu_op),
    .a   (alu_a),
    .b   (alu_b),
    .res (alu_res)
  );

  assign div_ok = !alu_res[EXT_W];

  always_comb begin
    sat = neg_r ? (acc_r > VNEG) : (acc_r > VPOS);
    if (neg_r) begin
      vel_nxt = sat ? VNEG[VEL_W-1:0] : alu_res[VEL_W-1:0];
    end else begin
      vel_nxt = sat ? VPOS[VEL_W-1:0] : acc_r[VEL_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      fin_r <= 1'b0;
      first_r <= 1'b1;
      last_pos_r <= '0;
      last_vel_r <= '0;
      hold_cnt_r <= COUNT_WIDTH'(1);
      rate_r <= SAMPLE_RATE_RST;
      limit_r <= HOLD_LIMIT_RST;
      out_valid_r <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end

      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          REG_SAMPLE_RATE: rate_r <= cfg_data;
          REG_HOLD_LIMIT:  limit_r <= cfg_data[HL_W-1:0];
          default: begin
          end
        endcase
      end

      if (fin_r) begin
        if (out_free) begin
          out_vel_r <= one_tout ? '0 : vel_nxt;
          out_held_r <= 1'b0;
          out_tout_r <= one_tout;
          last_vel_r <= vel_nxt;
          hold_cnt_r <= COUNT_WIDTH'(1);
          fin_r <= 1'b0;
        end
      end else begin
        unique case (state_r)
          ST_IDLE: begin
            if (in_acc) begin
              if (first_r) begin
                first_r <= 1'b0;
                last_pos_r <= in_position;
                out_vel_r <= '0;
                out_held_r <= 1'b0;
                out_tout_r <= 1'b0;
              end else if (same) begin
                hold_cnt_r <= cnt_inc;
                out_vel_r <= inc_tout ? '0 : last_vel_r;
                out_held_r <= 1'b1;
                out_tout_r <= inc_tout;
              end else begin
                last_pos_r <= in_position;
                mag_r <= diff;
                neg_r <= diff[MAG_W-1];
                state_r <= ST_ABS;
              end
            end
          end
          ST_ABS: begin
            if (neg_r) begin
              mag_r <= alu_res[MAG_W-1:0];
            end
            acc_r <= '0;
            step_r <= STEP_W'(SR_W - 1);
            state_r <= ST_MUL;
          end
          ST_MUL: begin
            acc_r <= alu_res[EXT_W-1:0];
            if (step_r == '0) begin
              rem_r <= '0;
              step_r <= STEP_W'(PROD_W - 1);
              state_r <= ST_DIV;
            end else begin
              step_r <= step_r - STEP_W'(1);
            end
          end
          ST_DIV: begin
            acc_r <= EXT_W'({acc_r[PROD_W-2:0], div_ok});
            rem_r <= div_ok ? alu_res[COUNT_WIDTH-1:0] : trial[COUNT_WIDTH-1:0];
            if (step_r == '0) begin
              fin_r <= 1'b1;
              state_r <= ST_IDLE;
            end else begin
              step_r <= step_r - STEP_W'(1);
            end
          end
          default: state_r <= ST_IDLE;
        endcase
      end
    end
  end

  a_cnt_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    hold_cnt_r != '0)
    else $error("hold count reached zero");

  a_rem_below_div: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DIV && !fin_r) |-> (rem_r < divisor))
    else $error("divide remainder not below divisor");

  a_tout_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_tout_r) |-> (out_vel_r == '0))
    else $error("timed-out item with nonzero velocity");

  a_abs_to_mul: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_ABS && !fin_r) |=> (state_r == ST_MUL && step_r == STEP_W'(SR_W - 1)))
    else $error("multiply did not start after abs step");

endmodule
